[rtl/daq_event_word_deframer_unit_assert.svh]
// Assertion macros for the event word deframer.
// Included by the top level; depends on nothing else.
`ifndef DAQ_EVENT_WORD_DEFRAMER_UNIT_ASSERT_SVH
`define DAQ_EVENT_WORD_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DEWD_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("deframer check failed");
`define DEWD_ASSERT_NXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("deframer check failed");
`else
`define DEWD_ASSERT_IMP(label, clk, rst, cond, expr)
`define DEWD_ASSERT_NXT(label, clk, rst, cond, expr)
`endif
`endif

[rtl/dewd_pkg.sv]
// Shared types and constants of the event word deframer.
// Used by the channel interfaces and the top level; depends on nothing.
package dewd_pkg;

   localparam int WORD_W      = 32;
   localparam int BOARD_W     = 8;
   localparam int LINK_W      = 6;
   localparam int CHIP_W      = 5;
   localparam int CHAN_W      = 6;
   localparam int BUNCH_W     = 4;
   localparam int COUNT_W     = 17;
   localparam int MAX_LINKS   = 64;
   localparam int MAX_BUNCHES = 16;
   localparam int MAP_BITS    = 40;
   localparam int LINK_BANKS  = 4;
   localparam int BANK_W      = $clog2(LINK_BANKS);
   localparam int BANK_DEPTH  = MAX_LINKS / LINK_BANKS;
   localparam int MAP_IDX_W   = $clog2(MAP_BITS);

   localparam logic [WORD_W-1:0]    PREFIX_WORD    = 32'h1111_1111;
   localparam logic [3:0]           VERSION_ONE    = 4'd1;
   localparam logic [3:0]           VERSION_TWO    = 4'd2;
   localparam logic [3:0]           HPAD_WORDS     = 4'd8;
   localparam logic [MAP_IDX_W-1:0] CH_ROC_HEADER  = 6'd0;
   localparam logic [MAP_IDX_W-1:0] CH_COMMON_MODE = 6'd19;
   localparam logic [MAP_IDX_W-1:0] CH_CRC         = 6'd39;
   localparam logic [CHAN_W-1:0]    CHAN_WRAP      = 6'd36;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_SIGNAL = 4'd1,
      PH_EVHEAD = 4'd2,
      PH_SLEN   = 4'd3,
      PH_HPAD   = 4'd4,
      PH_BH1    = 4'd5,
      PH_BH2    = 4'd6,
      PH_LLEN   = 4'd7,
      PH_MAPHI  = 4'd8,
      PH_MAPLO  = 4'd9,
      PH_CHAN   = 4'd10,
      PH_FCRC   = 4'd11,
      PH_BPAD   = 4'd12
   } phase_type;

   typedef enum logic [0:0] {
      KIND_DATA          = 1'b0,
      KIND_VERSION_ERROR = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type            result_kind;
      logic [BOARD_W-1:0]  board_id;
      logic [LINK_W-1:0]   link_number;
      logic [CHIP_W-1:0]   chip_number;
      logic [CHAN_W-1:0]   chip_channel;
      logic [BUNCH_W-1:0]  bunch_index;
      logic [WORD_W-1:0]   sample_word;
   } rsp_type;

endpackage

[rtl/dewd_if.sv]
// Valid/ready channel interfaces for the stream words and the channel results.
// Depends on dewd_pkg for the field widths.
interface dewd_req_if;
   logic                        valid;
   logic                        ready;
   logic [dewd_pkg::WORD_W-1:0] data_word;
   logic                        event_start;

   modport source (output valid, output data_word, output event_start, input ready);
   modport sink (input valid, input data_word, input event_start, output ready);
endinterface

interface dewd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         result_kind;
   logic [dewd_pkg::BOARD_W-1:0] board_id;
   logic [dewd_pkg::LINK_W-1:0]  link_number;
   logic [dewd_pkg::CHIP_W-1:0]  chip_number;
   logic [dewd_pkg::CHAN_W-1:0]  chip_channel;
   logic [dewd_pkg::BUNCH_W-1:0] bunch_index;
   logic [dewd_pkg::WORD_W-1:0]  sample_word;

   modport source (output valid, output result_kind, output board_id, output link_number,
                   output chip_number, output chip_channel, output bunch_index,
                   output sample_word, input ready);
   modport sink (input valid, input result_kind, input board_id, input link_number,
                 input chip_number, input chip_channel, input bunch_index,
                 input sample_word, output ready);
endinterface

[rtl/dewd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dewd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

[rtl/daq_event_word_deframer_unit.sv]
// Event word deframer top level: parser state, link length banks, result stage.
// Depends on dewd_pkg, dewd_if.sv, dewd_ram and the assertion macro header.
//
// The req channel takes one 32-bit stream word per handshake, with event_start
// set on the first word of each event. The rsp channel gives one result word per
// data channel of each link and bunch, or one error word for a bad format version.
// Every other word is consumed without a result.
// A word is accepted in any cycle while the skid register is empty, so the
// sustained rate is one word per clock. Results are registered in the result
// register, or in the one-deep skid register while that one is held; the two
// hold up to two, so a stalled receiver stops req only once both are full.
// The per-link lengths sit in four banks of registered-read RAM, one per byte of
// a length word, and are read while the first map word of a link is parsed.
// Synchronous reset returns the parser to waiting for an event start and empties
// both result registers.
`include "daq_event_word_deframer_unit_assert.svh"

module daq_event_word_deframer_unit (
   input logic  clock,
   input logic  reset,
   dewd_req_if.sink   req_chan,
   dewd_rsp_if.source rsp_chan
);

   import dewd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [COUNT_W-1:0]     words_seen_ff, words_seen_in;
   logic [COUNT_W-1:0]     event_words_ff, event_words_in;
   logic                   v2_ff, v2_in;
   logic [BOARD_W-1:0]     board_ff, board_in;
   logic [BUNCH_W-1:0]     bunch_total_ff, bunch_total_in;
   logic [MAX_BUNCHES-1:0] odd_ff, odd_in;
   logic [3:0]             hdr_words_ff, hdr_words_in;
   logic [BUNCH_W-1:0]     bunch_count_ff, bunch_count_in;
   logic [LINK_W-1:0]      link_total_ff, link_total_in;
   logic [LINK_W-1:0]      link_cursor_ff, link_cursor_in;
   logic [LINK_W-1:0]      chan_left_ff, chan_left_in;
   logic [MAP_BITS-1:0]    map_ff, map_in;

   rsp_type out_ff, out_in, skid_ff, skid_in;
   logic    rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   rsp_type emit_data;
   logic    emit_valid;

   logic                  req_fire, out_fire;
   logic [WORD_W-1:0]     w;
   logic [COUNT_W-1:0]    ws_bump;
   logic                  more_links;
   logic [LINK_W-1:0]     link_len;
   logic [LINK_W-1:0]     len_sel;
   logic                  map_hit;
   logic [MAP_IDX_W-1:0]  map_idx;
   logic [CHAN_W-1:0]     chan_base;
   logic [LINK_BANKS-1:0] lens_we;
   logic [LINK_W-1:0]     lens_wdata [LINK_BANKS];
   logic [LINK_W-1:0]     lens_rdata [LINK_BANKS];
   logic [4:0]            slen_idx;
   logic [LINK_W:0]       llen_idx;

   function automatic phase_type bunch_phase(input logic [COUNT_W-1:0] ws,
                                             input logic [COUNT_W-1:0] ew);
      return (ws < ew) ? PH_BH1 : PH_IDLE;
   endfunction

   function automatic phase_type header_phase(input logic [3:0] hwr,
                                              input logic [BUNCH_W-1:0] bt,
                                              input logic v2,
                                              input logic [COUNT_W-1:0] ws,
                                              input logic [COUNT_W-1:0] ew);
      if ({hwr, 1'b0} < {1'b0, bt}) begin
         return PH_SLEN;
      end else if (v2 && (hwr < HPAD_WORDS)) begin
         return PH_HPAD;
      end
      return bunch_phase(ws, ew);
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_fire = rsp_valid_ff && rsp_chan.ready;
   assign w        = req_chan.data_word;
   assign ws_bump  = (words_seen_ff != '1) ? words_seen_ff + COUNT_W'(1) : words_seen_ff;
   assign more_links = ({1'b0, link_cursor_ff} + (LINK_W+1)'(1)) < {1'b0, link_total_ff};

   genvar b;
   generate
      for (b = 0; b < LINK_BANKS; b++) begin : g_len_bank
         assign lens_wdata[b] = w[8*b +: LINK_W];
         dewd_ram #(
            .WIDTH (LINK_W),
            .DEPTH (BANK_DEPTH)
         ) u_len_ram (
            .clock      (clock),
            .wr_en      (lens_we[b]),
            .wr_addr    (link_cursor_ff[LINK_W-1:BANK_W]),
            .wr_data    (lens_wdata[b]),
            .rd_addr    (link_cursor_ff[LINK_W-1:BANK_W]),
            .rd_data_ff (lens_rdata[b])
         );
      end
   endgenerate

   assign link_len = lens_rdata[link_cursor_ff[BANK_W-1:0]];
   assign len_sel  = (link_len >= LINK_W'(2)) ? link_len - LINK_W'(2) : '0;

   always_comb begin
      map_hit = 1'b0;
      map_idx = '0;
      for (int i = MAP_BITS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            map_hit = 1'b1;
            map_idx = MAP_IDX_W'(i);
         end
      end
   end

   always_comb begin
      chan_base = map_idx - CHAN_W'(1) - ((map_idx > CH_COMMON_MODE) ? CHAN_W'(1) : CHAN_W'(0));
      if (chan_base >= CHAN_WRAP) begin
         chan_base = chan_base - CHAN_WRAP;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      words_seen_in  = words_seen_ff;
      event_words_in = event_words_ff;
      v2_in          = v2_ff;
      board_in       = board_ff;
      bunch_total_in = bunch_total_ff;
      odd_in         = odd_ff;
      hdr_words_in   = hdr_words_ff;
      bunch_count_in = bunch_count_ff;
      link_total_in  = link_total_ff;
      link_cursor_in = link_cursor_ff;
      chan_left_in   = chan_left_ff;
      map_in         = map_ff;
      lens_we        = '0;
      emit_valid     = 1'b0;
      emit_data      = '0;
      slen_idx       = '0;
      llen_idx       = '0;

      if (req_fire) begin
         if (req_chan.event_start) begin
            words_seen_in  = '0;
            bunch_count_in = '0;
            hdr_words_in   = '0;
            phase_in       = (w == PREFIX_WORD) ? PH_SIGNAL : PH_EVHEAD;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_SIGNAL: begin
                  phase_in = PH_EVHEAD;
               end
               PH_EVHEAD: begin
                  words_seen_in = COUNT_W'(1);
                  if (w[31:28] == VERSION_ONE || w[31:28] == VERSION_TWO) begin
                     v2_in = (w[31:28] == VERSION_TWO);
                     if (w[31:28] == VERSION_ONE) begin
                        event_words_in = COUNT_W'(w[15:0]);
                     end else if (w[15:0] == 16'd0) begin
                        event_words_in = '0;
                     end else begin
                        event_words_in = {w[15:0], 1'b0} - COUNT_W'(1);
                     end
                     board_in       = w[27:20];
                     bunch_total_in = w[19:16];
                     hdr_words_in   = '0;
                     bunch_count_in = '0;
                     phase_in = header_phase(4'd0, w[19:16], v2_in, COUNT_W'(1),
                                             event_words_in);
                  end else begin
                     emit_valid            = 1'b1;
                     emit_data.result_kind = KIND_VERSION_ERROR;
                     phase_in              = PH_IDLE;
                  end
               end
               PH_SLEN: begin
                  words_seen_in = ws_bump;
                  for (int k = 0; k < 2; k++) begin
                     slen_idx = {hdr_words_ff, 1'b0} + 5'(k);
                     if (slen_idx < {1'b0, bunch_total_ff}) begin
                        odd_in[slen_idx[BUNCH_W-1:0]] = w[16*k];
                     end
                  end
                  hdr_words_in = hdr_words_ff + 4'd1;
                  phase_in = header_phase(hdr_words_in, bunch_total_ff, v2_ff, ws_bump,
                                          event_words_ff);
               end
               PH_HPAD: begin
                  words_seen_in = ws_bump;
                  hdr_words_in  = hdr_words_ff + 4'd1;
                  phase_in = header_phase(hdr_words_in, bunch_total_ff, v2_ff, ws_bump,
                                          event_words_ff);
               end
               PH_BH1: begin
                  words_seen_in = ws_bump;
                  link_total_in = w[19:14];
                  board_in      = w[27:20];
                  phase_in      = PH_BH2;
               end
               PH_BH2: begin
                  words_seen_in  = ws_bump;
                  link_cursor_in = '0;
                  phase_in       = (link_total_ff != '0) ? PH_LLEN : PH_FCRC;
               end
               PH_LLEN: begin
                  words_seen_in = ws_bump;
                  for (int k = 0; k < LINK_BANKS; k++) begin
                     llen_idx   = {1'b0, link_cursor_ff} + (LINK_W+1)'(k);
                     lens_we[k] = (llen_idx < {1'b0, link_total_ff});
                  end
                  if (({1'b0, link_cursor_ff} + (LINK_W+1)'(LINK_BANKS))
                      >= {1'b0, link_total_ff}) begin
                     link_cursor_in = '0;
                     phase_in       = PH_MAPHI;
                  end else begin
                     link_cursor_in = link_cursor_ff + LINK_W'(LINK_BANKS);
                  end
               end
               PH_MAPHI: begin
                  words_seen_in = ws_bump;
                  map_in        = {w[MAP_BITS-WORD_W-1:0], {WORD_W{1'b0}}};
                  phase_in      = PH_MAPLO;
               end
               PH_MAPLO: begin
                  words_seen_in = ws_bump;
                  map_in        = {map_ff[MAP_BITS-1:WORD_W], w};
                  chan_left_in  = len_sel;
                  if (len_sel != '0) begin
                     phase_in = PH_CHAN;
                  end else if (more_links) begin
                     link_cursor_in = link_cursor_ff + LINK_W'(1);
                     phase_in       = PH_MAPHI;
                  end else begin
                     phase_in = PH_FCRC;
                  end
               end
               PH_CHAN: begin
                  words_seen_in = ws_bump;
                  if (map_hit) begin
                     map_in[map_idx] = 1'b0;
                     if (map_idx != CH_ROC_HEADER && map_idx != CH_COMMON_MODE &&
                         map_idx != CH_CRC) begin
                        emit_valid             = 1'b1;
                        emit_data.result_kind  = KIND_DATA;
                        emit_data.board_id     = board_ff;
                        emit_data.link_number  = link_cursor_ff;
                        emit_data.chip_number  = link_cursor_ff[LINK_W-1:1];
                        emit_data.chip_channel = chan_base;
                        emit_data.bunch_index  = bunch_count_ff;
                        emit_data.sample_word  = w;
                     end
                  end
                  if (chan_left_ff != '0) begin
                     chan_left_in = chan_left_ff - LINK_W'(1);
                  end
                  if (chan_left_in == '0) begin
                     if (more_links) begin
                        link_cursor_in = link_cursor_ff + LINK_W'(1);
                        phase_in       = PH_MAPHI;
                     end else begin
                        phase_in = PH_FCRC;
                     end
                  end
               end
               PH_FCRC: begin
                  words_seen_in = ws_bump;
                  if (v2_ff && (bunch_count_ff < bunch_total_ff) && odd_ff[bunch_count_ff]) begin
                     phase_in = PH_BPAD;
                  end else begin
                     bunch_count_in = bunch_count_ff + BUNCH_W'(1);
                     phase_in       = bunch_phase(ws_bump, event_words_ff);
                  end
               end
               PH_BPAD: begin
                  words_seen_in  = ws_bump;
                  bunch_count_in = bunch_count_ff + BUNCH_W'(1);
                  phase_in       = bunch_phase(ws_bump, event_words_ff);
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (emit_valid) begin
         if (!rsp_valid_ff || out_fire) begin
            out_in       = emit_data;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = emit_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         words_seen_ff  <= '0;
         event_words_ff <= '0;
         v2_ff          <= 1'b0;
         board_ff       <= '0;
         bunch_total_ff <= '0;
         hdr_words_ff   <= '0;
         bunch_count_ff <= '0;
         link_total_ff  <= '0;
         link_cursor_ff <= '0;
         chan_left_ff   <= '0;
         map_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         words_seen_ff  <= words_seen_in;
         event_words_ff <= event_words_in;
         v2_ff          <= v2_in;
         board_ff       <= board_in;
         bunch_total_ff <= bunch_total_in;
         hdr_words_ff   <= hdr_words_in;
         bunch_count_ff <= bunch_count_in;
         link_total_ff  <= link_total_in;
         link_cursor_ff <= link_cursor_in;
         chan_left_ff   <= chan_left_in;
         map_ff         <= map_in;
         rsp_valid_ff   <= rsp_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      odd_ff  <= odd_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_chan.ready        = !skid_valid_ff;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = out_ff.result_kind;
   assign rsp_chan.board_id     = out_ff.board_id;
   assign rsp_chan.link_number  = out_ff.link_number;
   assign rsp_chan.chip_number  = out_ff.chip_number;
   assign rsp_chan.chip_channel = out_ff.chip_channel;
   assign rsp_chan.bunch_index  = out_ff.bunch_index;
   assign rsp_chan.sample_word  = out_ff.sample_word;

   `DEWD_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `DEWD_ASSERT_IMP(a_chan_has_words, clock, reset, phase_ff == PH_CHAN, chan_left_ff != '0)
   `DEWD_ASSERT_IMP(a_cursor_in_range, clock, reset, phase_ff == PH_MAPHI || phase_ff == PH_MAPLO || phase_ff == PH_CHAN, link_cursor_ff < link_total_ff)
   `DEWD_ASSERT_NXT(a_error_to_idle, clock, reset, emit_valid && emit_data.result_kind == KIND_VERSION_ERROR, phase_ff == PH_IDLE)

endmodule

[tb/tb_daq_event_word_deframer_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the event word deframer: a directed table, then random events.
// Depends on dewd_pkg, the channel interfaces in dewd_if.sv and the deframer top level.
module tb_daq_event_word_deframer_unit;
   import dewd_pkg::*;

   localparam int RANDOM_WORDS = 850;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum logic [1:0] {
      RULE_PREDICT       = 2'd0,
      RULE_NONE          = 2'd1,
      RULE_VERSION_ERROR = 2'd2
   } check_rule_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              start;
      check_rule_type    rule;
   } stream_word_type;

   localparam int DIRECTED_ROWS = 24;
   localparam stream_word_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'hFFFF_FFFF, 1'b0, RULE_NONE},
      '{32'h0000_0000, 1'b0, RULE_NONE},
      '{PREFIX_WORD,   1'b1, RULE_NONE},
      '{32'h0000_0000, 1'b0, RULE_NONE},
      '{32'hF000_0000, 1'b0, RULE_VERSION_ERROR},
      '{32'h0000_0000, 1'b1, RULE_NONE},
      '{32'h0FF0_0005, 1'b0, RULE_VERSION_ERROR},
      '{32'h0000_0000, 1'b1, RULE_NONE},
      '{32'h1FF1_000F, 1'b0, RULE_PREDICT},
      '{32'h0000_0003, 1'b0, RULE_PREDICT},
      '{32'h0AB0_8000, 1'b0, RULE_PREDICT},
      '{32'hFFFF_FFFF, 1'b0, RULE_PREDICT},
      '{32'h0000_C1C7, 1'b0, RULE_PREDICT},
      '{32'hFFFF_FF40, 1'b0, RULE_PREDICT},
      '{32'h0008_0003, 1'b0, RULE_PREDICT},
      '{32'hFFFF_FFFF, 1'b0, RULE_PREDICT},
      '{32'h0000_0000, 1'b0, RULE_PREDICT},
      '{32'h1234_5678, 1'b0, RULE_PREDICT},
      '{32'h89AB_CDEF, 1'b0, RULE_PREDICT},
      '{32'h5A5A_5A5A, 1'b0, RULE_PREDICT},
      '{32'h0000_0000, 1'b0, RULE_PREDICT},
      '{32'hFFFF_FFFF, 1'b0, RULE_PREDICT},
      '{32'h0000_0000, 1'b0, RULE_PREDICT},
      '{32'hFFFF_FFFF, 1'b0, RULE_NONE}
   };

   logic clock;
   logic reset;
   logic feeding;

   dewd_req_if req_chan ();
   dewd_rsp_if rsp_chan ();

   daq_event_word_deframer_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   stream_word_type stream_words[$];
   rsp_type         pending_results[$];

   int unsigned cycle_count = 0;
   int unsigned next_word = 0;
   int unsigned words_taken = 0;
   int unsigned burst_left = 16;
   int unsigned gap_left = 0;
   int unsigned mismatches = 0;
   int unsigned data_results = 0;
   int unsigned error_results = 0;
   int unsigned events_built = 0;
   logic [31:0] stall_pat;

   // Parser state of the predictor.
   phase_type          phase = PH_IDLE;
   logic [COUNT_W-1:0] seen_cnt = '0;
   logic [COUNT_W-1:0] ev_len = '0;
   logic               fmt_v2 = 1'b0;
   logic [BOARD_W-1:0] cur_board = '0;
   logic [3:0]         n_samples = '0;
   logic               sample_odd [MAX_BUNCHES] = '{default: 1'b0};
   logic [3:0]         hdr_cnt = '0;
   logic [BUNCH_W-1:0] bunch_no = '0;
   logic [LINK_W-1:0]  n_links = '0;
   logic [LINK_W-1:0]  link_len [MAX_LINKS] = '{default: '0};
   logic [LINK_W-1:0]  link_idx = '0;
   logic [LINK_W-1:0]  chan_left = '0;
   logic [MAP_BITS-1:0] unused_map = '0;

   function automatic void count_word();
      if (seen_cnt != {COUNT_W{1'b1}})
         seen_cnt = seen_cnt + 1'b1;
   endfunction

   function automatic void open_next_bunch();
      phase = (seen_cnt < ev_len) ? PH_BH1 : PH_IDLE;
   endfunction

   function automatic void after_header();
      if (int'(hdr_cnt) * 2 < int'(n_samples))
         phase = PH_SLEN;
      else if (fmt_v2 && hdr_cnt < HPAD_WORDS)
         phase = PH_HPAD;
      else
         open_next_bunch();
   endfunction

   function automatic void close_bunch();
      bunch_no = bunch_no + 1'b1;
      open_next_bunch();
   endfunction

   function automatic void finish_link();
      if (int'(link_idx) + 1 < int'(n_links)) begin
         link_idx = link_idx + 1'b1;
         phase = PH_MAPHI;
      end else begin
         phase = PH_FCRC;
      end
   endfunction

   function automatic bit deframe_step(input logic [WORD_W-1:0] w, input logic opens_event,
                                       output rsp_type r);
      int unsigned pos;
      int unsigned bit_no;
      int unsigned chan;
      logic [3:0]  ver;
      logic        odd;
      bit          produced;
      r = '0;
      produced = 1'b0;
      if (opens_event) begin
         seen_cnt = '0;
         bunch_no = '0;
         hdr_cnt = '0;
         phase = (w == PREFIX_WORD) ? PH_SIGNAL : PH_EVHEAD;
         return 1'b0;
      end
      case (phase)
         PH_IDLE: ;
         PH_SIGNAL: phase = PH_EVHEAD;
         PH_EVHEAD: begin
            ver = w[31:28];
            seen_cnt = 17'd1;
            if (ver == VERSION_ONE) begin
               fmt_v2 = 1'b0;
               ev_len = {1'b0, w[15:0]};
            end else if (ver == VERSION_TWO) begin
               fmt_v2 = 1'b1;
               ev_len = (w[15:0] == 16'd0) ? 17'd0 : {w[15:0], 1'b0} - 17'd1;
            end else begin
               r.result_kind = KIND_VERSION_ERROR;
               phase = PH_IDLE;
               return 1'b1;
            end
            cur_board = w[27:20];
            n_samples = w[19:16];
            hdr_cnt = '0;
            bunch_no = '0;
            after_header();
         end
         PH_SLEN: begin
            count_word();
            for (int k = 0; k < 2; k++) begin
               pos = int'(hdr_cnt) * 2 + k;
               if (pos < n_samples)
                  sample_odd[pos[BUNCH_W-1:0]] = w[16 * k];
            end
            hdr_cnt = hdr_cnt + 1'b1;
            after_header();
         end
         PH_HPAD: begin
            count_word();
            hdr_cnt = hdr_cnt + 1'b1;
            after_header();
         end
         PH_BH1: begin
            count_word();
            n_links = w[19:14];
            cur_board = w[27:20];
            phase = PH_BH2;
         end
         PH_BH2: begin
            count_word();
            link_idx = '0;
            phase = (n_links != '0) ? PH_LLEN : PH_FCRC;
         end
         PH_LLEN: begin
            count_word();
            for (int k = 0; k < 4; k++) begin
               pos = int'(link_idx) + k;
               if (pos < n_links)
                  link_len[pos[LINK_W-1:0]] = w[8 * k +: 6];
            end
            if (int'(link_idx) + 4 >= int'(n_links)) begin
               link_idx = '0;
               phase = PH_MAPHI;
            end else begin
               link_idx = link_idx + 6'd4;
            end
         end
         PH_MAPHI: begin
            count_word();
            unused_map = {w[7:0], 32'h0};
            phase = PH_MAPLO;
         end
         PH_MAPLO: begin
            count_word();
            unused_map[31:0] = w;
            chan_left = (link_len[link_idx] >= 6'd2) ? link_len[link_idx] - 6'd2 : '0;
            if (chan_left == '0)
               finish_link();
            else
               phase = PH_CHAN;
         end
         PH_CHAN: begin
            count_word();
            bit_no = MAP_BITS;
            for (pos = MAP_BITS; pos > 0; pos--)
               if (unused_map[pos - 1])
                  bit_no = pos - 1;
            if (bit_no < MAP_BITS) begin
               unused_map[bit_no] = 1'b0;
               if (bit_no != CH_ROC_HEADER && bit_no != CH_COMMON_MODE && bit_no != CH_CRC) begin
                  chan = bit_no - 1 - ((bit_no > CH_COMMON_MODE) ? 1 : 0);
                  if (chan >= CHAN_WRAP)
                     chan = chan - CHAN_WRAP;
                  r.result_kind = KIND_DATA;
                  r.board_id = cur_board;
                  r.link_number = link_idx;
                  r.chip_number = link_idx[5:1];
                  r.chip_channel = chan[CHAN_W-1:0];
                  r.bunch_index = bunch_no;
                  r.sample_word = w;
                  produced = 1'b1;
               end
            end
            if (chan_left != '0)
               chan_left = chan_left - 1'b1;
            if (chan_left == '0)
               finish_link();
         end
         PH_FCRC: begin
            count_word();
            odd = (bunch_no < n_samples) ? sample_odd[bunch_no] : 1'b0;
            if (fmt_v2 && odd)
               phase = PH_BPAD;
            else
               close_bunch();
         end
         PH_BPAD: begin
            count_word();
            close_bunch();
         end
         default: phase = PH_IDLE;
      endcase
      return produced;
   endfunction

   task automatic push_word(input logic [WORD_W-1:0] w, input logic s);
      stream_word_type item;
      item.word = w;
      item.start = s;
      item.rule = RULE_PREDICT;
      stream_words.push_back(item);
   endtask

   // Most events are well formed with random content; the rest carry a bad version,
   // random noise after the header, a random length or a cut that forces a restart.
   task automatic build_event();
      logic [WORD_W-1:0] body[$];
      logic              odd_of [MAX_BUNCHES];
      logic [LINK_W-1:0] lens [MAX_LINKS];
      logic [WORD_W-1:0] w;
      int unsigned shape, ver, n_samp, n_bunch, n_lnk, len_val, cut, pick;
      events_built++;
      shape = $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 1) begin
         push_word(PREFIX_WORD, 1'b1);
         push_word($urandom, 1'b0);
      end else begin
         push_word($urandom, 1'b1);
      end
      if (shape == 0) begin
         ver = $urandom_range(3, 16) % 16;
         w = $urandom;
         w[31:28] = ver[3:0];
         push_word(w, 1'b0);
         repeat ($urandom_range(0, 2)) push_word($urandom, 1'b0);
         return;
      end
      ver = ($urandom_range(0, 2) == 0) ? 2 : 1;
      n_samp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      for (int i = 0; i < MAX_BUNCHES; i++)
         odd_of[BUNCH_W'(i)] = 1'b0;
      n_bunch = 0;
      if (shape == 1) begin
         repeat ($urandom_range(1, 12)) body.push_back($urandom);
      end else begin
         for (int i = 0; i < (n_samp + 1) / 2; i++) begin
            w = $urandom;
            odd_of[BUNCH_W'(2 * i)] = w[0];
            odd_of[BUNCH_W'(2 * i + 1)] = w[16];
            body.push_back(w);
         end
         if (ver == 2)
            while (body.size() < HPAD_WORDS)
               body.push_back($urandom);
         pick = $urandom_range(0, 19);
         n_bunch = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(16, 18) : $urandom_range(1, 3);
         for (int b = 0; b < n_bunch; b++) begin
            if (n_bunch > 3)
               n_lnk = $urandom_range(0, 1);
            else if ($urandom_range(0, 19) == 0)
               n_lnk = $urandom_range(5, 63);
            else
               n_lnk = $urandom_range(0, 4);
            w = $urandom;
            w[19:14] = n_lnk[5:0];
            body.push_back(w);
            body.push_back($urandom);
            for (int l = 0; l < n_lnk; l++)
               lens[LINK_W'(l)] = LINK_W'((n_lnk <= 4 && $urandom_range(0, 9) == 0) ?
                                          $urandom_range(0, 63) : $urandom_range(0, 8));
            for (int l = 0; l < n_lnk; l += 4) begin
               w = $urandom;
               for (int k = 0; k < 4; k++)
                  if (l + k < n_lnk)
                     w[8 * k +: 6] = lens[LINK_W'(l + k)];
               body.push_back(w);
            end
            for (int l = 0; l < n_lnk; l++) begin
               body.push_back($urandom);
               w = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
               body.push_back(w);
               for (int k = 2; k < lens[LINK_W'(l)]; k++)
                  body.push_back($urandom);
            end
            body.push_back($urandom);
            if (ver == 2 && (b % 16) < n_samp && odd_of[BUNCH_W'(b)])
               body.push_back($urandom);
         end
      end
      if (ver == 1)
         len_val = body.size() + 1;
      else if (n_bunch == 0 && $urandom_range(0, 1) == 1)
         len_val = 0;
      else
         len_val = (body.size() + 2) / 2;
      if ($urandom_range(0, 7) == 0)
         len_val = $urandom_range(0, 65535);
      w = $urandom;
      w[31:28] = ver[3:0];
      w[19:16] = n_samp[3:0];
      w[15:0] = len_val[15:0];
      push_word(w, 1'b0);
      cut = body.size();
      if ($urandom_range(0, 7) == 0 && body.size() > 0)
         cut = $urandom_range(0, body.size() - 1);
      for (int i = 0; i < cut; i++)
         push_word(body[i], 1'b0);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_word($urandom, 1'b0);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock)
      cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (feeding) begin
         if (req_chan.valid && req_chan.ready) begin
            next_word++;
            if (burst_left > 0)
               burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
         if (req_chan.valid && !req_chan.ready) begin
         end else if (gap_left > 0 || next_word >= stream_words.size()) begin
            if (gap_left > 0)
               gap_left--;
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid <= 1'b1;
            req_chan.data_word <= stream_words[next_word].word;
            req_chan.event_start <= stream_words[next_word].start;
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count[5:0] == 6'd0) begin
         case ($urandom_range(0, 3))
            0: stall_pat <= 32'hFFFF_FFFF;
            1: stall_pat <= $urandom | $urandom;
            2: stall_pat <= $urandom & $urandom;
            default: stall_pat <= $urandom;
         endcase
      end
      rsp_chan.ready <= reset ? 1'b0 : stall_pat[cycle_count[4:0]];
   end

   rsp_type predicted;
   rsp_type oldest;
   bit      produces;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            produces = deframe_step(req_chan.data_word, req_chan.event_start, predicted);
            case (stream_words[words_taken].rule)
               RULE_NONE: produces = 1'b0;
               RULE_VERSION_ERROR: begin
                  produces = 1'b1;
                  predicted = '0;
                  predicted.result_kind = KIND_VERSION_ERROR;
               end
               default: ;
            endcase
            if (produces)
               pending_results.push_back(predicted);
            words_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing pending: kind %0d, sample_word 0x%0h",
                      rsp_chan.result_kind, rsp_chan.sample_word);
               mismatches++;
            end else begin
               oldest = pending_results.pop_front();
               check_field("result_kind", 32'(oldest.result_kind),
                           32'(rsp_chan.result_kind));
               check_field("board_id", 32'(oldest.board_id), 32'(rsp_chan.board_id));
               check_field("link_number", 32'(oldest.link_number),
                           32'(rsp_chan.link_number));
               check_field("chip_number", 32'(oldest.chip_number),
                           32'(rsp_chan.chip_number));
               check_field("chip_channel", 32'(oldest.chip_channel),
                           32'(rsp_chan.chip_channel));
               check_field("bunch_index", 32'(oldest.bunch_index),
                           32'(rsp_chan.bunch_index));
               check_field("sample_word", oldest.sample_word, rsp_chan.sample_word);
               if (oldest.result_kind == KIND_VERSION_ERROR)
                  error_results++;
               else
                  data_results++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d of %0d words taken.",
               cycle_count, words_taken, stream_words.size());
      $display("daq_event_word_deframer_unit test failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      feeding = 1'b0;
      stall_pat = 32'hFFFF_FFFF;
      req_chan.valid = 1'b0;
      req_chan.data_word = '0;
      req_chan.event_start = 1'b0;
      rsp_chan.ready = 1'b0;
      foreach (DIRECTED[i])
         stream_words.push_back(DIRECTED[i]);
      while (stream_words.size() < DIRECTED_ROWS + RANDOM_WORDS)
         build_event();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      feeding <= 1'b1;
      do
         @(negedge clock);
      while (words_taken != stream_words.size() || pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         mismatches++;
      end
      $display("Streamed %0d words in %0d random events plus the directed table.",
               stream_words.size(), events_built);
      $display("Checked %0d channel results and %0d version errors; %0d mismatches.",
               data_results, error_results, mismatches);
      if (mismatches == 0)
         $display("daq_event_word_deframer_unit test passed");
      else
         $display("daq_event_word_deframer_unit test failed");
      $finish;
   end

endmodule
